FILE: sv/pce_pkg.sv
// Shared types and constants for the configuration bus enumerator.
// Used by pce_res_queue, pci_config_bus_enumerator and the bench; depends on nothing.
package pce_pkg;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_RESP  = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        KIND_REQ   = 3'd0,
        KIND_REC   = 3'd1,
        KIND_DONE  = 3'd2,
        KIND_ENTRY = 3'd3,
        KIND_NONE  = 3'd4,
        KIND_UNEXP = 3'd5
    } t_kind;

    typedef enum logic [2:0] {
        PH_SLOT     = 3'd0,
        PH_FN_ID    = 3'd1,
        PH_FN_CLASS = 3'd2,
        PH_FN_HDR   = 3'd3,
        PH_DEV_HDR  = 3'd4,
        PH_MF_ID    = 3'd5
    } t_phase;

    localparam logic [7:0]  OFF_ID        = 8'h00;
    localparam logic [7:0]  OFF_CLASS     = 8'h08;
    localparam logic [7:0]  OFF_HDR       = 8'h0C;
    localparam logic [7:0]  OFF_MASK      = 8'hFC;
    localparam logic [31:0] CFG_ENABLE    = 32'h8000_0000;
    localparam logic [15:0] ABSENT_ID     = 16'hFFFF;
    localparam logic [7:0]  MF_BIT        = 8'h80;
    localparam int          BUS_COUNT     = 256;
    localparam logic [7:0]  LAST_BUS      = 8'(BUS_COUNT - 1);
    localparam logic [4:0]  LAST_DEVICE   = 5'd31;
    localparam logic [2:0]  LAST_FUNCTION = 3'd7;
    localparam int          RES_DEPTH     = 4;

    typedef struct packed {
        logic [7:0]  bus;
        logic [4:0]  dev;
        logic [2:0]  fn;
        logic [15:0] product;
        logic [15:0] vendor;
        logic [31:0] class_rev;
        logic [7:0]  header;
    } t_entry;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] cfg_address;
        t_entry      dev_info;
        logic [7:0]  found_count;
        logic        last;
    } t_result;

    function automatic logic [31:0] make_cfg_addr(input logic [7:0] bus,
                                                  input logic [4:0] dev,
                                                  input logic [2:0] fn,
                                                  input logic [7:0] off);
        logic [7:0] off_m;
        off_m = off & OFF_MASK;
        return CFG_ENABLE | {8'h00, bus, dev, fn, off_m};
    endfunction

endpackage

FILE: sv/pce_res_queue.sv
// Result queue: takes up to two result words per cycle, hands out one while i_ready is high.
// Depends on pce_pkg for t_result and RES_DEPTH.
module pce_res_queue import pce_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [1:0] i_push_n,
    input  t_result    i_push_a,
    input  t_result    i_push_b,
    output logic       o_room,
    output logic       o_valid,
    input  logic       i_ready,
    output t_result    o_data
);

    localparam int PW = $clog2(RES_DEPTH);
    localparam int NW = $clog2(RES_DEPTH + 1);

    t_result         r_q [RES_DEPTH];
    logic [PW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [NW-1:0]   r_cnt, n_cnt;
    logic            pop;
    logic [PW-1:0]   wr_ptr_b;

    assign o_valid  = (r_cnt != '0);
    assign o_data   = r_q[r_rd_ptr];
    assign o_room   = (r_cnt <= NW'(RES_DEPTH - 2));
    assign pop      = o_valid && i_ready;
    assign wr_ptr_b = r_wr_ptr + PW'(1);

    always_comb begin
        n_wr_ptr = r_wr_ptr + PW'(i_push_n);
        n_rd_ptr = pop ? r_rd_ptr + PW'(1) : r_rd_ptr;
        n_cnt    = r_cnt + NW'(i_push_n) - NW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push_n != 2'd0) begin
            r_q[r_wr_ptr] <= i_push_a;
        end
        if (i_push_n == 2'd2) begin
            r_q[wr_ptr_b] <= i_push_b;
        end
    end

endmodule

FILE: sv/pci_config_bus_enumerator.sv
// Top level of the configuration bus enumerator: walk sequencer, device table, result queue.
// Depends on pce_pkg and pce_res_queue.
//
// Accepts one input word per cycle. A word is registered together with its table read,
// worked out by the walk logic from those registers once the result queue has room, and
// queued as up to two result words (none for a NOP). The input side stalls only
// while the four-deep result queue cannot take two more words. The device table is a
// single-write, single-read memory of TABLE_ENTRIES words with a forwarding path for a
// read that meets a write of the same entry.
module pci_config_bus_enumerator import pce_pkg::*; #(
    parameter int TABLE_ENTRIES = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_cmd,
    input  logic [31:0] i_read_data,
    input  logic [7:0]  i_entry_index,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_kind,
    output logic [31:0] o_cfg_address,
    output logic [7:0]  o_bus_number,
    output logic [4:0]  o_device_number,
    output logic [2:0]  o_function_number,
    output logic [15:0] o_vendor_id,
    output logic [15:0] o_product_id,
    output logic [31:0] o_class_revision,
    output logic [7:0]  o_header_kind,
    output logic [7:0]  o_found_count,
    output logic        o_last_result
);

    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);

    t_entry          r_tbl [TABLE_ENTRIES];

    logic            r_scanning, n_scanning;
    logic [7:0]      r_bus, n_bus;
    logic [4:0]      r_dev, n_dev;
    logic [2:0]      r_fn, n_fn;
    t_phase          r_phase, n_phase;
    logic [31:0]     r_ids, n_ids;
    logic [31:0]     r_class, n_class;
    logic [CW-1:0]   r_count, n_count;

    logic            r_s1_valid;
    t_cmd            r_cmd;
    logic [31:0]     r_data;
    logic [7:0]      r_idx;
    t_entry          r_rd_data;
    t_entry          r_byp_data;
    logic            r_byp;

    logic            in_accept;
    logic            s1_fire;
    logic            q_room;
    t_entry          rd_entry;
    logic            tbl_we;
    logic [AW-1:0]   tbl_waddr;
    t_entry          tbl_wdata;

    logic            absent;
    logic            adv;
    logic            aft;
    logic            rec;
    logic            req;
    logic            done;
    logic [7:0]      req_off;
    logic            single;
    t_kind           single_kind;
    logic            hit;
    t_entry          rec_entry;
    logic [8:0]      count_w;
    logic [1:0]      n_res;
    t_result         res_a, res_b, follow;
    t_result         q_out;

    assign in_accept = i_valid && o_ready;
    assign s1_fire   = r_s1_valid && q_room;
    assign o_ready   = !r_s1_valid || s1_fire;
    assign rd_entry  = r_byp ? r_byp_data : r_rd_data;
    assign absent    = (r_data[15:0] == ABSENT_ID);

    always_comb begin
        n_scanning  = r_scanning;
        n_bus       = r_bus;
        n_dev       = r_dev;
        n_fn        = r_fn;
        n_phase     = r_phase;
        n_ids       = r_ids;
        n_class     = r_class;
        n_count     = r_count;
        adv         = 1'b0;
        aft         = 1'b0;
        rec         = 1'b0;
        req         = 1'b0;
        done        = 1'b0;
        req_off     = OFF_ID;
        single      = 1'b0;
        single_kind = KIND_NONE;
        tbl_we      = 1'b0;
        hit         = ({1'b0, r_idx} < 9'(r_count));

        unique case (r_cmd)
            CMD_START: begin
                n_count    = '0;
                n_bus      = '0;
                n_dev      = '0;
                n_fn       = '0;
                n_phase    = PH_SLOT;
                n_ids      = '0;
                n_class    = '0;
                n_scanning = 1'b1;
                req        = 1'b1;
            end
            CMD_RESP: begin
                if (!r_scanning) begin
                    single      = 1'b1;
                    single_kind = KIND_UNEXP;
                end else begin
                    unique case (r_phase)
                        PH_SLOT: begin
                            if (absent) begin
                                adv = 1'b1;
                            end else begin
                                n_fn    = '0;
                                n_phase = PH_FN_ID;
                                req     = 1'b1;
                            end
                        end
                        PH_FN_ID: begin
                            if (absent || r_count >= CW'(TABLE_ENTRIES)) begin
                                aft = 1'b1;
                            end else begin
                                n_ids   = r_data;
                                n_phase = PH_FN_CLASS;
                                req     = 1'b1;
                                req_off = OFF_CLASS;
                            end
                        end
                        PH_FN_CLASS: begin
                            n_class = r_data;
                            n_phase = PH_FN_HDR;
                            req     = 1'b1;
                            req_off = OFF_HDR;
                        end
                        PH_FN_HDR: begin
                            rec = 1'b1;
                            aft = 1'b1;
                            if (r_count < CW'(TABLE_ENTRIES)) begin
                                tbl_we  = s1_fire;
                                n_count = r_count + CW'(1);
                            end
                        end
                        PH_DEV_HDR: begin
                            if ((r_data[23:16] & MF_BIT) != 8'h00) begin
                                n_fn    = 3'd1;
                                n_phase = PH_MF_ID;
                                req     = 1'b1;
                            end else begin
                                adv = 1'b1;
                            end
                        end
                        PH_MF_ID: begin
                            if (absent) begin
                                aft = 1'b1;
                            end else begin
                                n_phase = PH_FN_ID;
                                req     = 1'b1;
                            end
                        end
                        default: begin
                            adv = 1'b1;
                        end
                    endcase

                    if (aft) begin
                        priority if (r_fn == 3'd0) begin
                            n_phase = PH_DEV_HDR;
                            req     = 1'b1;
                            req_off = OFF_HDR;
                        end else if (r_fn == LAST_FUNCTION) begin
                            adv = 1'b1;
                        end else begin
                            n_fn    = r_fn + 3'd1;
                            n_phase = PH_MF_ID;
                            req     = 1'b1;
                        end
                    end

                    if (adv) begin
                        n_fn    = '0;
                        n_phase = PH_SLOT;
                        if (r_dev == LAST_DEVICE) begin
                            n_dev = '0;
                            if (r_bus >= LAST_BUS) begin
                                n_scanning = 1'b0;
                                n_bus      = '0;
                                done       = 1'b1;
                            end else begin
                                n_bus = r_bus + 8'd1;
                                req   = 1'b1;
                            end
                        end else begin
                            n_dev = r_dev + 5'd1;
                            req   = 1'b1;
                        end
                    end
                end
            end
            CMD_READ: begin
                single      = 1'b1;
                single_kind = hit ? KIND_ENTRY : KIND_NONE;
            end
            CMD_NOP: begin
            end
        endcase
    end

    always_comb begin
        count_w   = 9'(n_count);
        rec_entry = '{bus: r_bus, dev: r_dev, fn: r_fn, product: r_ids[31:16],
                      vendor: r_ids[15:0], class_rev: r_class, header: r_data[23:16]};
        tbl_wdata = rec_entry;
        tbl_waddr = r_count[AW-1:0];

        follow             = '0;
        follow.found_count = count_w[7:0];
        follow.last        = 1'b1;
        if (done) begin
            follow.kind = KIND_DONE;
        end else begin
            follow.kind        = KIND_REQ;
            follow.cfg_address = make_cfg_addr(n_bus, n_dev, n_fn, req_off);
        end

        res_a = follow;
        res_b = follow;
        n_res = 2'd0;
        priority if (rec) begin
            res_a          = '0;
            res_a.kind     = KIND_REC;
            res_a.dev_info = rec_entry;
            res_a.found_count = count_w[7:0];
            n_res          = 2'd2;
        end else if (req || done) begin
            n_res = 2'd1;
        end else if (single) begin
            res_a             = '0;
            res_a.kind        = single_kind;
            res_a.found_count = count_w[7:0];
            res_a.last        = 1'b1;
            if (single_kind == KIND_ENTRY) begin
                res_a.dev_info = rd_entry;
            end
            n_res = 2'd1;
        end else begin
            n_res = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scanning <= 1'b0;
            r_bus      <= '0;
            r_dev      <= '0;
            r_fn       <= '0;
            r_phase    <= PH_SLOT;
            r_ids      <= '0;
            r_class    <= '0;
            r_count    <= '0;
            r_s1_valid <= 1'b0;
            r_cmd      <= CMD_NOP;
        end else begin
            if (s1_fire) begin
                r_scanning <= n_scanning;
                r_bus      <= n_bus;
                r_dev      <= n_dev;
                r_fn       <= n_fn;
                r_phase    <= n_phase;
                r_ids      <= n_ids;
                r_class    <= n_class;
                r_count    <= n_count;
            end
            if (in_accept) begin
                r_s1_valid <= 1'b1;
                r_cmd      <= t_cmd'(i_cmd);
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_data     <= i_read_data;
            r_idx      <= i_entry_index;
            r_byp      <= tbl_we && (tbl_waddr == i_entry_index[AW-1:0]);
            r_byp_data <= tbl_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (tbl_we) begin
            r_tbl[tbl_waddr] <= tbl_wdata;
        end
        if (in_accept) begin
            r_rd_data <= r_tbl[i_entry_index[AW-1:0]];
        end
    end

    pce_res_queue u_res_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_n (s1_fire ? n_res : 2'd0),
        .i_push_a (res_a),
        .i_push_b (res_b),
        .o_room   (q_room),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_data   (q_out)
    );

    assign o_kind            = q_out.kind;
    assign o_cfg_address     = q_out.cfg_address;
    assign o_bus_number      = q_out.dev_info.bus;
    assign o_device_number   = q_out.dev_info.dev;
    assign o_function_number = q_out.dev_info.fn;
    assign o_vendor_id       = q_out.dev_info.vendor;
    assign o_product_id      = q_out.dev_info.product;
    assign o_class_revision  = q_out.dev_info.class_rev;
    assign o_header_kind     = q_out.dev_info.header;
    assign o_found_count     = q_out.found_count;
    assign o_last_result     = q_out.last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_ENTRIES))
        else $error("device count beyond table size");

    a_write_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tbl_we |-> (r_scanning && r_phase == PH_FN_HDR && r_cmd == CMD_RESP))
        else $error("table written outside a header response");

    a_start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && r_cmd == CMD_START) |=> (r_scanning && r_count == '0
            && r_phase == PH_SLOT))
        else $error("start did not restart the walk");

    a_done_idles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && done) |=> (!r_scanning && r_bus == '0))
        else $error("walk still active after scan done");

endmodule

FILE: bench/pci_config_bus_enumerator_tb.sv
// Self-checking bench for pci_config_bus_enumerator: bus walk, device table and read-back.
// Keeps its own copy of the walk state and table to predict every result word.
// Depends on pce_pkg and the enumerator RTL.
module pci_config_bus_enumerator_tb;
    import pce_pkg::*;

    localparam int     TABLE_ENTRIES = 128;
    localparam int     HALF_PERIOD   = 2;
    localparam int     RESET_CYCLES  = 6;
    localparam int     LONG_HOLD     = 150;
    localparam int     DRAIN_LIMIT   = 4000;
    localparam int     SETTLE_CYCLES = 12;
    localparam longint RUN_LIMIT     = 64'd4_000_000;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [1:0]  i_cmd;
    logic [31:0] i_read_data;
    logic [7:0]  i_entry_index;
    logic        o_valid;
    logic        i_ready;
    logic [2:0]  o_kind;
    logic [31:0] o_cfg_address;
    logic [7:0]  o_bus_number;
    logic [4:0]  o_device_number;
    logic [2:0]  o_function_number;
    logic [15:0] o_vendor_id;
    logic [15:0] o_product_id;
    logic [31:0] o_class_revision;
    logic [7:0]  o_header_kind;
    logic [7:0]  o_found_count;
    logic        o_last_result;

    // walk state and device table as the block should hold them
    logic        scan_active = 1'b0;
    logic [7:0]  cur_bus     = '0;
    logic [4:0]  cur_dev     = '0;
    logic [2:0]  cur_fn      = '0;
    t_phase      cur_phase   = PH_SLOT;
    logic [31:0] held_ids    = '0;
    logic [31:0] held_class  = '0;
    int          found_total = 0;
    t_entry      found_table [TABLE_ENTRIES];

    t_result     step_words [$];
    t_result     awaited_words [$];

    int          present_pct = 50;
    int          mf_pct      = 40;
    bit          steady_flow = 1'b0;
    bit          hold_off_req = 1'b0;

    int          error_count    = 0;
    int          sent_words     = 0;
    int          checked_words  = 0;
    int          recorded_seen  = 0;
    int          scans_finished = 0;
    int          entries_read   = 0;

    pci_config_bus_enumerator #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_cmd            (i_cmd),
        .i_read_data      (i_read_data),
        .i_entry_index    (i_entry_index),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_kind           (o_kind),
        .o_cfg_address    (o_cfg_address),
        .o_bus_number     (o_bus_number),
        .o_device_number  (o_device_number),
        .o_function_number(o_function_number),
        .o_vendor_id      (o_vendor_id),
        .o_product_id     (o_product_id),
        .o_class_revision (o_class_revision),
        .o_header_kind    (o_header_kind),
        .o_found_count    (o_found_count),
        .o_last_result    (o_last_result)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    function automatic int gap_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        if (roll < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void queue_word(t_kind kind, logic [31:0] addr, t_entry info);
        t_result w;
        w.kind        = kind;
        w.cfg_address = addr;
        w.dev_info    = info;
        w.found_count = 8'(found_total);
        w.last        = 1'b0;
        step_words.push_back(w);
    endfunction

    function automatic void request_read(logic [7:0] offset);
        queue_word(KIND_REQ, CFG_ENABLE | {8'h00, cur_bus, cur_dev, cur_fn, offset & OFF_MASK},
                   '0);
    endfunction

    function automatic void next_slot();
        cur_fn    = '0;
        cur_phase = PH_SLOT;
        if (cur_dev == LAST_DEVICE) begin
            cur_dev = '0;
            if (cur_bus == LAST_BUS) begin
                scan_active = 1'b0;
                cur_bus     = '0;
                queue_word(KIND_DONE, '0, '0);
                return;
            end
            cur_bus = cur_bus + 8'd1;
        end else begin
            cur_dev = cur_dev + 5'd1;
        end
        request_read(OFF_ID);
    endfunction

    function automatic void function_done();
        if (cur_fn == 3'd0) begin
            cur_phase = PH_DEV_HDR;
            request_read(OFF_HDR);
        end else if (cur_fn == LAST_FUNCTION) begin
            next_slot();
        end else begin
            cur_fn    = cur_fn + 3'd1;
            cur_phase = PH_MF_ID;
            request_read(OFF_ID);
        end
    endfunction

    function automatic void take_reply(logic [31:0] data);
        logic   absent;
        t_entry rec;
        absent = (data[15:0] == ABSENT_ID);
        case (cur_phase)
            PH_SLOT: begin
                if (absent) begin
                    next_slot();
                end else begin
                    cur_fn    = '0;
                    cur_phase = PH_FN_ID;
                    request_read(OFF_ID);
                end
            end
            PH_FN_ID: begin
                if (absent || found_total >= TABLE_ENTRIES) begin
                    function_done();
                end else begin
                    held_ids  = data;
                    cur_phase = PH_FN_CLASS;
                    request_read(OFF_CLASS);
                end
            end
            PH_FN_CLASS: begin
                held_class = data;
                cur_phase  = PH_FN_HDR;
                request_read(OFF_HDR);
            end
            PH_FN_HDR: begin
                rec.bus       = cur_bus;
                rec.dev       = cur_dev;
                rec.fn        = cur_fn;
                rec.product   = held_ids[31:16];
                rec.vendor    = held_ids[15:0];
                rec.class_rev = held_class;
                rec.header    = data[23:16];
                if (found_total < TABLE_ENTRIES) begin
                    found_table[found_total] = rec;
                    found_total++;
                end
                queue_word(KIND_REC, '0, rec);
                function_done();
            end
            PH_DEV_HDR: begin
                if ((data[23:16] & MF_BIT) != 8'h00) begin
                    cur_fn    = 3'd1;
                    cur_phase = PH_MF_ID;
                    request_read(OFF_ID);
                end else begin
                    next_slot();
                end
            end
            PH_MF_ID: begin
                if (absent) begin
                    function_done();
                end else begin
                    cur_phase = PH_FN_ID;
                    request_read(OFF_ID);
                end
            end
            default: begin
                next_slot();
            end
        endcase
    endfunction

    function automatic void enumerate_step(t_cmd cmd, logic [31:0] data, logic [7:0] idx);
        t_result tail;
        step_words.delete();
        case (cmd)
            CMD_START: begin
                found_total = 0;
                cur_bus     = '0;
                cur_dev     = '0;
                cur_fn      = '0;
                cur_phase   = PH_SLOT;
                held_ids    = '0;
                held_class  = '0;
                scan_active = 1'b1;
                request_read(OFF_ID);
            end
            CMD_RESP: begin
                if (scan_active) take_reply(data);
                else queue_word(KIND_UNEXP, '0, '0);
            end
            CMD_READ: begin
                if (int'(idx) < found_total) queue_word(KIND_ENTRY, '0, found_table[idx]);
                else queue_word(KIND_NONE, '0, '0);
            end
            default: begin
            end
        endcase
        if (step_words.size() > 0) begin
            tail      = step_words.pop_back();
            tail.last = 1'b1;
            step_words.push_back(tail);
        end
        foreach (step_words[i]) awaited_words.push_back(step_words[i]);
    endfunction

    function automatic logic [31:0] pick_reply();
        logic [31:0] word;
        word = $urandom();
        case (cur_phase)
            PH_SLOT, PH_MF_ID: begin
                if ($urandom_range(0, 99) < present_pct) begin
                    if (word[15:0] == ABSENT_ID) word[0] = 1'b0;
                end else begin
                    word[15:0] = ABSENT_ID;
                end
            end
            PH_FN_ID: begin
                if ($urandom_range(0, 99) < 8) word[15:0] = ABSENT_ID;
                else if (word[15:0] == ABSENT_ID) word[0] = 1'b0;
            end
            PH_DEV_HDR: begin
                word[23] = ($urandom_range(0, 99) < mf_pct);
            end
            default: begin
            end
        endcase
        return word;
    endfunction

    function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t mismatch on %s: expected %h, got %h", $time, name, want, got);
            error_count++;
        end
    endfunction

    task automatic send_word(input t_cmd cmd, input logic [31:0] data, input logic [7:0] idx);
        int gap;
        i_valid       <= 1'b1;
        i_cmd         <= cmd;
        i_read_data   <= data;
        i_entry_index <= idx;
        do @(posedge i_clk); while (!o_ready);
        enumerate_step(cmd, data, idx);
        sent_words++;
        gap = steady_flow ? 0 : gap_len();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_reply();
        send_word(CMD_RESP, pick_reply(), 8'($urandom()));
    endtask

    task automatic send_read();
        logic [7:0] idx;
        if (found_total > 0 && $urandom_range(0, 1) == 0) idx = 8'($urandom_range(0, found_total - 1));
        else idx = 8'($urandom_range(0, 255));
        send_word(CMD_READ, $urandom(), idx);
    endtask

    task automatic test_idle_commands();
        send_word(CMD_RESP, 32'h0000_0000, 8'h00);
        send_word(CMD_RESP, 32'hFFFF_FFFF, 8'hFF);
        send_word(CMD_READ, 32'h0000_0000, 8'h00);
        send_word(CMD_READ, 32'hFFFF_FFFF, 8'hFF);
        send_word(CMD_NOP, 32'hFFFF_FFFF, 8'hFF);
    endtask

    task automatic test_directed_walk();
        send_word(CMD_START, 32'h0000_0000, 8'h00);
        send_word(CMD_RESP, 32'h1111_8086, 8'h00);
        send_word(CMD_RESP, 32'hABCD_8086, 8'h00);
        send_word(CMD_RESP, 32'hFFFF_FFFF, 8'h00);
        send_word(CMD_RESP, 32'h0080_0000, 8'h00);
        // function 0 header says multi-function: probe 1..7
        send_word(CMD_RESP, 32'hFF80_FFFF, 8'h00);
        send_word(CMD_RESP, 32'h0000_FFFF, 8'h00);
        send_word(CMD_RESP, 32'h0000_0000, 8'h00);
        // present on probe, gone on the second ID read
        send_word(CMD_RESP, 32'hFFFF_FFFF, 8'h00);
        send_word(CMD_RESP, 32'h0000_0000, 8'h00);
        send_word(CMD_RESP, 32'h0000_0000, 8'h00);
        send_word(CMD_RESP, 32'hFFFF_0000, 8'h00);
        send_word(CMD_RESP, 32'h0000_0000, 8'h00);
        send_word(CMD_READ, 32'h0000_0000, 8'h00);
        send_word(CMD_READ, 32'h0000_0000, 8'h01);
        send_word(CMD_READ, 32'h0000_0000, 8'h02);
        send_word(CMD_READ, 32'h0000_0000, 8'hFF);
        send_word(CMD_START, 32'hFFFF_FFFF, 8'hFF);
        send_word(CMD_RESP, 32'h0000_FFFF, 8'h00);
        send_word(CMD_NOP, 32'h0000_0000, 8'h00);
    endtask

    task automatic test_random_walks(input int count);
        int pick;
        present_pct = 50;
        mf_pct      = 40;
        for (int k = 0; k < count; k++) begin
            steady_flow = ((k / 20) % 3 == 2);
            pick = $urandom_range(0, 99);
            if (scan_active) begin
                if (pick < 86) send_reply();
                else if (pick < 92) send_read();
                else if (pick < 94) send_word(CMD_START, $urandom(), 8'($urandom()));
                else if (pick < 97) send_word(CMD_NOP, $urandom(), 8'($urandom()));
                else send_word(CMD_RESP, $urandom(), 8'($urandom()));
            end else begin
                if (pick < 50) send_word(CMD_START, $urandom(), 8'($urandom()));
                else if (pick < 75) send_read();
                else if (pick < 88) send_word(CMD_RESP, $urandom(), 8'($urandom()));
                else send_word(CMD_NOP, $urandom(), 8'($urandom()));
            end
        end
        steady_flow = 1'b0;
    endtask

    task automatic test_back_pressure();
        steady_flow  = 1'b1;
        hold_off_req = 1'b1;
        repeat (40) begin
            if (scan_active) send_reply();
            else send_word(CMD_START, $urandom(), 8'($urandom()));
        end
        steady_flow = 1'b0;
    endtask

    task automatic test_table_fill();
        present_pct = 95;
        mf_pct      = 90;
        send_word(CMD_START, $urandom(), 8'($urandom()));
        while (scan_active && found_total < TABLE_ENTRIES) send_reply();
        // table full: later devices are skipped
        present_pct = 60;
        repeat (30) begin
            if (scan_active) send_reply();
        end
    endtask

    task automatic test_table_readback();
        send_word(CMD_READ, $urandom(), 8'h00);
        send_word(CMD_READ, $urandom(), 8'(TABLE_ENTRIES - 1));
        send_word(CMD_READ, $urandom(), 8'(TABLE_ENTRIES));
        send_word(CMD_READ, $urandom(), 8'hFF);
        repeat (30) send_read();
        send_word(CMD_RESP, $urandom(), 8'($urandom()));
        send_word(CMD_NOP, $urandom(), 8'($urandom()));
    endtask

    task automatic drain_results();
        int waited;
        waited = 0;
        i_valid <= 1'b0;
        while (awaited_words.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (awaited_words.size() != 0) begin
            $display("%0t drain timeout: %0d words still expected", $time, awaited_words.size());
            error_count++;
        end
    endtask

    initial begin
        int stall;
        i_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (hold_off_req) begin
                stall        = LONG_HOLD;
                hold_off_req = 1'b0;
            end else begin
                stall = steady_flow ? 0 : gap_len();
            end
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (awaited_words.size() == 0) begin
                $display("%0t unexpected result word: expected none, got kind %0d address %h",
                         $time, o_kind, o_cfg_address);
                error_count++;
            end else begin
                want = awaited_words.pop_front();
                compare_field("kind", 32'(want.kind), 32'(o_kind));
                compare_field("cfg_address", want.cfg_address, o_cfg_address);
                compare_field("bus_number", 32'(want.dev_info.bus), 32'(o_bus_number));
                compare_field("device_number", 32'(want.dev_info.dev), 32'(o_device_number));
                compare_field("function_number", 32'(want.dev_info.fn), 32'(o_function_number));
                compare_field("vendor_id", 32'(want.dev_info.vendor), 32'(o_vendor_id));
                compare_field("product_id", 32'(want.dev_info.product), 32'(o_product_id));
                compare_field("class_revision", want.dev_info.class_rev, o_class_revision);
                compare_field("header_kind", 32'(want.dev_info.header), 32'(o_header_kind));
                compare_field("found_count", 32'(want.found_count), 32'(o_found_count));
                compare_field("last_result", 32'(want.last), 32'(o_last_result));
                checked_words++;
                case (want.kind)
                    KIND_REC:   recorded_seen++;
                    KIND_DONE:  scans_finished++;
                    KIND_ENTRY: entries_read++;
                    default: begin
                    end
                endcase
            end
        end
    end

    initial begin
        #(RUN_LIMIT);
        $display("FAIL");
        $finish;
    end

    initial begin
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_cmd         = CMD_NOP;
        i_read_data   = '0;
        i_entry_index = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_idle_commands();
        test_directed_walk();
        test_random_walks(60);
        test_back_pressure();
        test_table_fill();
        test_table_readback();
        drain_results();
        $display("Covered %0d input words and %0d result words, %0d devices recorded,",
                 sent_words, checked_words, recorded_seen);
        $display("%0d complete bus sweeps, %0d table entries read back, %0d mismatches.",
                 scans_finished, entries_read, error_count);
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

FILE: sim.f
sv/pce_pkg.sv
sv/pce_res_queue.sv
sv/pci_config_bus_enumerator.sv
bench/pci_config_bus_enumerator_tb.sv
